// ===== src/g5c_pkg.sv =====
`default_nettype none

package g5c_pkg;

   // Graph geometry
   localparam int unsigned NumVertices = 5;
   localparam int unsigned NumPairs    = 10;
   localparam int unsigned NumDegrees  = 5;
   localparam int unsigned VertW       = 3;
   localparam int unsigned DegW        = 3;
   localparam int unsigned CountW      = 3;
   localparam int unsigned IdW         = 5;

   // Ids chosen by the neighbor checks
   localparam logic [IdW-1:0] IdLeafNbDeg2 = 5'd9;
   localparam logic [IdW-1:0] IdLeafNbElse = 5'd3;
   localparam logic [IdW-1:0] IdHubAllDeg2 = 5'd6;
   localparam logic [IdW-1:0] IdHubElse    = 5'd12;
   localparam logic [IdW-1:0] IdNone       = 5'd0;

   typedef logic [NumPairs-1:0]               edge_type;
   typedef logic [VertW-1:0]                  vertex_type;
   typedef logic [DegW-1:0]                   degree_type;
   typedef degree_type [NumVertices-1:0]      degrees_type;
   typedef logic [CountW-1:0]                 count_type;
   typedef count_type [NumDegrees-1:0]        hist_type;

   typedef enum logic [1:0] {
      KindNone,
      KindDirect,
      KindLeaf,
      KindHub
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [IdW-1:0]    id;
   } match_type;

   // Stage beats
   typedef struct packed {
      edge_type    edges;
      degrees_type deg;
   } deg_beat_type;

   typedef struct packed {
      hist_type hist;
      logic     leaf_nb_deg2;
      logic     hub_all2;
   } feat_beat_type;

   typedef struct packed {
      logic [IdW-1:0] graphlet_id;
      logic           recognized;
   } rsp_beat_type;

   // Endpoints of each edge bit: 01,02,03,04,12,13,14,23,24,34
   localparam vertex_type PairA [NumPairs] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3
   };
   localparam vertex_type PairB [NumPairs] = '{
      3'd1, 3'd2, 3'd3, 3'd4, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4
   };

   // Adjacency of two vertices
   function automatic logic adj_bit(edge_type e, vertex_type a, vertex_type b);
      logic r;
      r = 1'b0;
      for (int p = 0; p < NumPairs; p++) begin
         if ((PairA[p] == a && PairB[p] == b) || (PairA[p] == b && PairB[p] == a)) begin
            r = e[p];
         end
      end
      return r;
   endfunction

   // Map the degree histogram (counts of degree 0..4) to a graphlet class
   function automatic match_type match_hist(hist_type h);
      match_type m;
      m.kind = KindDirect;
      m.id   = IdNone;
      case ({h[0], h[1], h[2], h[3], h[4]})
         {3'd0, 3'd2, 3'd3, 3'd0, 3'd0}: m.id = 5'd8;
         {3'd0, 3'd3, 3'd1, 3'd1, 3'd0}: m.id = 5'd1;
         {3'd0, 3'd4, 3'd0, 3'd0, 3'd1}: m.id = 5'd0;
         {3'd0, 3'd2, 3'd1, 3'd2, 3'd0}: m.id = 5'd4;
         {3'd0, 3'd1, 3'd3, 3'd1, 3'd0}: m.kind = KindLeaf;
         {3'd0, 3'd2, 3'd2, 3'd0, 3'd1}: m.id = 5'd2;
         {3'd0, 3'd0, 3'd5, 3'd0, 3'd0}: m.id = 5'd11;
         {3'd0, 3'd1, 3'd2, 3'd1, 3'd1}: m.id = 5'd5;
         {3'd0, 3'd0, 3'd4, 3'd0, 3'd1}: m.id = 5'd10;
         {3'd0, 3'd1, 3'd1, 3'd3, 3'd0}: m.id = 5'd14;
         {3'd0, 3'd0, 3'd3, 3'd2, 3'd0}: m.kind = KindHub;
         {3'd0, 3'd0, 3'd3, 3'd0, 3'd2}: m.id = 5'd7;
         {3'd0, 3'd1, 3'd0, 3'd3, 3'd1}: m.id = 5'd15;
         {3'd0, 3'd0, 3'd2, 3'd2, 3'd1}: m.id = 5'd13;
         {3'd0, 3'd0, 3'd1, 3'd4, 3'd0}: m.id = 5'd17;
         {3'd0, 3'd0, 3'd1, 3'd2, 3'd2}: m.id = 5'd16;
         {3'd0, 3'd0, 3'd0, 3'd4, 3'd1}: m.id = 5'd18;
         {3'd0, 3'd0, 3'd0, 3'd2, 3'd3}: m.id = 5'd19;
         {3'd0, 3'd0, 3'd0, 3'd0, 3'd5}: m.id = 5'd20;
         default:                        m.kind = KindNone;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== src/g5c_degree.sv =====
`default_nettype none

module g5c_degree
   import g5c_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire edge_type     in_edges,
   output logic              out_valid,
   input  wire logic         out_ready,
   output deg_beat_type      out_data
);

   logic         valid_ff;
   deg_beat_type data_ff;
   deg_beat_type data_in;

   // Count the edges touching each vertex
   always_comb begin
      data_in.edges = in_edges;
      for (int v = 0; v < NumVertices; v++) begin
         data_in.deg[v] = '0;
         for (int p = 0; p < NumPairs; p++) begin
            if (in_edges[p] && (PairA[p] == VertW'(v) || PairB[p] == VertW'(v))) begin
               data_in.deg[v] = data_in.deg[v] + 3'd1;
            end
         end
      end
   end

   // Advance when this slot is empty or being drained
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== src/g5c_features.sv =====
`default_nettype none

module g5c_features
   import g5c_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire deg_beat_type  in_data,
   output logic               out_valid,
   input  wire logic          out_ready,
   output feat_beat_type      out_data
);

   logic          valid_ff;
   feat_beat_type data_ff;
   feat_beat_type data_in;
   hist_type      deg_hist;
   logic          leaf_nb_deg2;
   logic          hub_all2;
   vertex_type    leaf;
   vertex_type    leaf_nb;
   vertex_type    hub;

   // Build the degree histogram
   always_comb begin
      for (int d = 0; d < NumDegrees; d++) begin
         deg_hist[d] = '0;
         for (int v = 0; v < NumVertices; v++) begin
            if (in_data.deg[v] == DegW'(d)) begin
               deg_hist[d] = deg_hist[d] + 3'd1;
            end
         end
      end
   end

   // Find the lowest degree-1 vertex and its lowest neighbor
   always_comb begin
      leaf = '0;
      for (int i = NumVertices - 1; i >= 0; i--) begin
         if (in_data.deg[i] == 3'd1) begin
            leaf = VertW'(i);
         end
      end
      leaf_nb = '0;
      for (int j = NumVertices - 1; j >= 0; j--) begin
         if (VertW'(j) != leaf && adj_bit(in_data.edges, leaf, VertW'(j))) begin
            leaf_nb = VertW'(j);
         end
      end
      leaf_nb_deg2 = (in_data.deg[leaf_nb] == 3'd2);
   end

   // Check that every neighbor of the lowest degree-3 vertex has degree 2
   always_comb begin
      hub = '0;
      for (int i = NumVertices - 1; i >= 0; i--) begin
         if (in_data.deg[i] == 3'd3) begin
            hub = VertW'(i);
         end
      end
      hub_all2 = 1'b1;
      for (int j = 0; j < NumVertices; j++) begin
         if (VertW'(j) != hub && adj_bit(in_data.edges, hub, VertW'(j))
             && in_data.deg[j] != 3'd2) begin
            hub_all2 = 1'b0;
         end
      end
   end

   // Gather the stage beat
   assign data_in = '{hist: deg_hist, leaf_nb_deg2: leaf_nb_deg2, hub_all2: hub_all2};

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== src/g5c_match.sv =====
`default_nettype none

module g5c_match
   import g5c_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire feat_beat_type  in_data,
   output logic                out_valid,
   input  wire logic           out_ready,
   output rsp_beat_type        out_data
);

   logic         valid_ff;
   rsp_beat_type data_ff;
   rsp_beat_type data_in;
   match_type    m;

   // Look up the histogram and resolve the two split sequences
   always_comb begin
      m = match_hist(in_data.hist);
      data_in.recognized = 1'b1;
      case (m.kind)
         KindNone: begin
            data_in.recognized  = 1'b0;
            data_in.graphlet_id = IdNone;
         end
         KindLeaf: data_in.graphlet_id = in_data.leaf_nb_deg2 ? IdLeafNbDeg2 : IdLeafNbElse;
         KindHub:  data_in.graphlet_id = in_data.hub_all2 ? IdHubAllDeg2 : IdHubElse;
         default:  data_in.graphlet_id = m.id;
      endcase
   end

   // Output register: holds a beat while the receiver stalls
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== src/graphlet5_classifier_top.sv =====
`default_nettype none

// Five-vertex graphlet classifier.
// Input stream (req_): one beat per graph, req_tdata[9:0] holds the edge
// bits for pairs 01,02,03,04,12,13,14,23,24,34 from bit 0 up; the upper
// bits of req_tdata are ignored.
// Result stream (rsp_): one beat per input beat, in order. rsp_tdata[4:0]
// holds the graphlet id, rsp_tuser says whether the degree pattern was
// recognized; an unrecognized graph returns id 0.
// Pipeline: three register stages (degree count, histogram and neighbor
// checks, table match into the output register).
// Throughput: one beat per cycle while rsp_tready stays high, with one
// slot per stage of the three-stage pipeline.
// Stall: each stage holds its beat while the one after it is full and not
// draining; req_tready falls only when all three stages are full and
// rsp_tready is low. Nothing is dropped or repeated.
// Reset: synchronous, clears all stage valid bits; in-flight beats are
// discarded and the block accepts again in the next cycle.

module graphlet5_classifier_top
   import g5c_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [9:0] edge_bits, [15:10] zero fill
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [4:0] graphlet_id, [7:5] zero fill
   output logic             rsp_tuser    // [0] recognized
);

   logic          s1_valid;
   logic          s1_ready;
   deg_beat_type  s1_data;
   logic          s2_valid;
   logic          s2_ready;
   feat_beat_type s2_data;
   rsp_beat_type  s3_data;

   g5c_degree u_degree (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_edges  (req_tdata[NumPairs-1:0]),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   g5c_features u_features (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   g5c_match u_match (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (s3_data)
   );

   // Pack the result beat
   assign rsp_tdata = {3'b000, s3_data.graphlet_id};
   assign rsp_tuser = s3_data.recognized;

endmodule

`default_nettype wire

// ===== src/g5c_checker.sv =====
`default_nettype none

module g5c_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tuser
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // Unrecognized graphs carry id zero
   a_unrec_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("unrecognized beat with nonzero id");

   // Ids stay in the class range
   a_id_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= 8'd20)
      else $error("graphlet id out of range");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("result beat right after reset");

endmodule

bind graphlet5_classifier_top g5c_checker u_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// Holds the graph classes still owed by the block and checks each result beat
// against the oldest of them.
class expected_classes;
   g5c_pkg::rsp_beat_type pending_classes[$];
   int unsigned           mismatch_count;

   function new();
      mismatch_count = 0;
   endfunction

   // Classify one edge set: degrees, sorted sequence, table, neighbor splits
   function automatic g5c_pkg::rsp_beat_type classify_graph(g5c_pkg::edge_type edges);
      g5c_pkg::rsp_beat_type cls;
      g5c_pkg::kind_type     kind;
      int unsigned           deg [5];
      int unsigned           srt [5];
      bit                    linked [5][5];
      int unsigned           key;
      int unsigned           swap;
      int                    leaf;
      int                    nb;
      int                    hub;
      bit                    all_two;
      for (int v = 0; v < 5; v++) begin
         deg[v] = 0;
         for (int w = 0; w < 5; w++) begin
            linked[v][w] = 1'b0;
         end
      end
      for (int p = 0; p < g5c_pkg::NumPairs; p++) begin
         if (edges[p]) begin
            linked[g5c_pkg::PairA[p]][g5c_pkg::PairB[p]] = 1'b1;
            linked[g5c_pkg::PairB[p]][g5c_pkg::PairA[p]] = 1'b1;
            deg[g5c_pkg::PairA[p]]++;
            deg[g5c_pkg::PairB[p]]++;
         end
      end

      // Sort ascending and pack the sequence as decimal digits
      srt = deg;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4 - i; j++) begin
            if (srt[j] > srt[j + 1]) begin
               swap       = srt[j];
               srt[j]     = srt[j + 1];
               srt[j + 1] = swap;
            end
         end
      end
      key = 0;
      for (int i = 0; i < 5; i++) begin
         key = key * 10 + srt[i];
      end

      kind = g5c_pkg::KindDirect;
      cls.graphlet_id = g5c_pkg::IdNone;
      case (key)
         11222: cls.graphlet_id = 5'd8;
         11123: cls.graphlet_id = 5'd1;
         11114: cls.graphlet_id = 5'd0;
         11233: cls.graphlet_id = 5'd4;
         12223: kind = g5c_pkg::KindLeaf;
         11224: cls.graphlet_id = 5'd2;
         22222: cls.graphlet_id = 5'd11;
         12234: cls.graphlet_id = 5'd5;
         22224: cls.graphlet_id = 5'd10;
         12333: cls.graphlet_id = 5'd14;
         22233: kind = g5c_pkg::KindHub;
         22244: cls.graphlet_id = 5'd7;
         13334: cls.graphlet_id = 5'd15;
         22334: cls.graphlet_id = 5'd13;
         23333: cls.graphlet_id = 5'd17;
         23344: cls.graphlet_id = 5'd16;
         33334: cls.graphlet_id = 5'd18;
         33444: cls.graphlet_id = 5'd19;
         44444: cls.graphlet_id = 5'd20;
         default: kind = g5c_pkg::KindNone;
      endcase

      // Leaf split: look at the one neighbor of the lowest degree-1 vertex
      if (kind == g5c_pkg::KindLeaf) begin
         leaf = -1;
         nb   = 0;
         for (int v = 0; v < 5; v++) begin
            if (leaf < 0 && deg[v] == 1) begin
               leaf = v;
            end
         end
         for (int v = 4; v >= 0; v--) begin
            if (v != leaf && linked[leaf][v]) begin
               nb = v;
            end
         end
         cls.graphlet_id = (deg[nb] == 2) ? g5c_pkg::IdLeafNbDeg2 : g5c_pkg::IdLeafNbElse;
      end

      // Hub split: all neighbors of the lowest degree-3 vertex of degree 2?
      if (kind == g5c_pkg::KindHub) begin
         hub     = -1;
         all_two = 1'b1;
         for (int v = 0; v < 5; v++) begin
            if (hub < 0 && deg[v] == 3) begin
               hub = v;
            end
         end
         for (int v = 0; v < 5; v++) begin
            if (v != hub && linked[hub][v] && deg[v] != 2) begin
               all_two = 1'b0;
            end
         end
         cls.graphlet_id = all_two ? g5c_pkg::IdHubAllDeg2 : g5c_pkg::IdHubElse;
      end

      cls.recognized = (kind != g5c_pkg::KindNone);
      return cls;
   endfunction

   // Append the class owed for an accepted edge set
   function void note_graph(g5c_pkg::edge_type edges);
      pending_classes.insert(pending_classes.size(), classify_graph(edges));
   endfunction

   function int unsigned pending();
      return pending_classes.size();
   endfunction

   // Compare one result beat with the oldest owed class
   function void check_class(logic [4:0] graphlet_id, logic recognized);
      g5c_pkg::rsp_beat_type want;
      if (pending_classes.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("%0t: unexpected result beat id=%0d recognized=%0b",
                     $realtime, graphlet_id, recognized);
         end
         return;
      end
      want = pending_classes.pop_front();
      if (graphlet_id !== want.graphlet_id || recognized !== want.recognized) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display({"%0t: class mismatch: expected id=%0d recognized=%0b,",
                      " got id=%0d recognized=%0b"},
                     $realtime, want.graphlet_id, want.recognized, graphlet_id, recognized);
         end
      end
   endfunction
endclass

module testbench;
   import g5c_pkg::*;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [9:0] edge_bits, [15:10] zero fill
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [4:0] graphlet_id, [7:5] zero fill
   logic        rsp_tuser;         // [0] recognized

   // When set, neither side idles
   bit steady = 1'b0;

   expected_classes results = new();

   graphlet5_classifier_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Offer one edge set after a random idle gap unless steady, and hold it until accepted
   task automatic send_graph(edge_type edges);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, edges};
      do @(posedge clock); while (!req_tready);
      results.note_graph(edges);
   endtask

   // Take result beats, holding rsp_tready low for a random stall after each unless steady
   initial begin : rsp_side
      int unsigned stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            results.check_class(rsp_tdata[4:0], rsp_tuser);
            stall = steady ? 0 : $urandom_range(0, 6);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      edge_type directed [$];
      directed = '{
         10'd0,      // no edges: nothing recognized
         10'h3FF,    // complete graph
         10'd15,     // star on vertex 0
         10'd657,    // path 0-1-2-3-4
         10'd659,    // leaf whose neighbor has degree 2
         10'd157,    // leaf hanging off a degree-3 vertex
         10'd126,    // two hubs, every hub neighbor of degree 2
         10'd667,    // ring of five vertices with a chord: hub sees another hub
         10'd531,    // triangle plus a separate edge: disconnected but matched
         10'd183,    // four-clique plus an isolated vertex
         10'h3FF ^ 10'd1,
         10'd1, 10'd2, 10'd4, 10'd8, 10'd16,
         10'd32, 10'd64, 10'd128, 10'd256, 10'd512
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_graph(directed[i]);
      end

      // Random edge sets in phases; every fourth phase runs without idling
      for (int i = 0; i < 1900; i++) begin
         if (i % 100 == 0) begin
            steady = ((i / 100) % 4 == 3);
         end
         send_graph(edge_type'($urandom_range(0, 1023)));
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      // Drain, then allow the pipeline depth for stray beats
      while (results.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (results.mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
